// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks (the filter top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/fir3_pkg.sv =====
// Shared constants, types and coefficient ROM of the three-axis FIR filter.
package fir3_pkg;

	localparam int TAP_COUNT_DEF       = 25;
	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int COEFF_FRAC_BITS_DEF = 23;

	localparam int ROM_TAPS      = 25;
	localparam int ROM_IDX_BITS  = $clog2(ROM_TAPS);
	localparam int ROM_FRAC_BITS = 23;
	localparam int ACC_BITS      = 32;
	localparam int DIGIT_BITS    = 4;
	localparam int AXES          = 3;

	// Symmetric Q1.23 coefficients, centre tap at index 12.
	localparam int COEFF_ROM [ROM_TAPS] = '{
		-63043, -90290, 84303, 15475, -166160, 191242, 36783, -386330,
		470808, 57059, -1143937, 2258543, 5657835, 2258543, -1143937,
		57059, 470808, -386330, 36783, 191242, -166160, 15475, 84303,
		-90290, -63043
	};

	// Per-cycle controls from the sequencer to each axis lane.
	typedef struct packed {
		logic load;   // shift a new sample into the delay line, clear the sum
		logic step;   // process one digit of the current tap
		logic first;  // first digit of a tap: take sample and coefficient fresh
		logic last;   // last (signed) digit of a tap: rotate the delay line
	} fir3_ctl_t;

	// Coefficient of one tap, rescaled to the requested fraction width.
	// Taps past the ROM are zero; narrowing the fraction truncates the magnitude.
	function automatic logic [ACC_BITS-1:0] tap_coeff(input int unsigned idx,
		input int frac_bits);
		logic [ACC_BITS-1:0] mag;
		logic                neg;
		int                  c;
		if (idx >= ROM_TAPS) begin
			return '0;
		end
		c   = COEFF_ROM[ROM_IDX_BITS'(idx)];
		neg = (c < 0);
		mag = neg ? ACC_BITS'(-c) : ACC_BITS'(c);
		if (frac_bits >= ROM_FRAC_BITS) begin
			mag = mag << (frac_bits - ROM_FRAC_BITS);
		end else begin
			mag = mag >> (ROM_FRAC_BITS - frac_bits);
		end
		return neg ? (~mag + 1'b1) : mag;
	endfunction

endpackage

// ===== hw/rtl/three_axis_fir_filter.sv =====
// Three-axis FIR filter top level: sequencer, three lanes and output register.
// Each beat runs a 4-bit digit multiply-accumulate in every lane, once per tap and digit; the
// result then goes to the output register and m_tvalid, which is registered. No new beat is taken
// until that result has been captured, which waits for the output register to be free.
// A finished result waits in the output register while the next beat is processed.
// Reset (arst_n low, asynchronous) clears all delay lines, the sequencer and m_tvalid.
`include "assert_macros.svh"

module three_axis_fir_filter #(
	parameter int TAP_COUNT       = fir3_pkg::TAP_COUNT_DEF,
	parameter int SAMPLE_BITS     = fir3_pkg::SAMPLE_BITS_DEF,
	parameter int COEFF_FRAC_BITS = fir3_pkg::COEFF_FRAC_BITS_DEF,
	localparam int IN_BITS  = ((fir3_pkg::AXES * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = fir3_pkg::AXES * fir3_pkg::ACC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// sample_x, sample_y, sample_z, zero fill to whole bytes
	input  logic [IN_BITS-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// filtered_x, filtered_y, filtered_z
	output logic [OUT_BITS-1:0] m_tdata
);

	localparam int AB = fir3_pkg::ACC_BITS;

	fir3_pkg::fir3_ctl_t ctl;
	logic [AB-1:0]       coeff;
	logic                capture;
	logic [AB-1:0]       acc [fir3_pkg::AXES];
	logic [OUT_BITS-1:0] m_tdata_q;

	fir3_ctrl #(
		.TAP_COUNT       (TAP_COUNT),
		.SAMPLE_BITS     (SAMPLE_BITS),
		.COEFF_FRAC_BITS (COEFF_FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl),
		.coeff    (coeff),
		.capture  (capture)
	);

	for (genvar a = 0; a < fir3_pkg::AXES; a++) begin : g_lane
		fir3_lane #(
			.TAP_COUNT   (TAP_COUNT),
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.coeff  (coeff),
			.sample (s_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]),
			.acc    (acc[a])
		);
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			for (int a = 0; a < fir3_pkg::AXES; a++) begin
				m_tdata_q[a*AB +: AB] <= acc[a];
			end
		end
	end

	assign m_tdata = m_tdata_q;

	`ASSERT_NEXT(a_capture_shows, clk, arst_n, capture, m_tvalid, "captured result not presented")
	`ASSERT_IMPLIES(a_capture_free, clk, arst_n, capture, (!m_tvalid || m_tready), "result overwritten before taken")
	`ASSERT_NEXT(a_busy_after_beat, clk, arst_n, (s_tvalid && s_tready), !s_tready, "input taken while busy")

endmodule

// ===== hw/rtl/fir3_lane.sv =====
// One axis: circulating delay line and a digit-serial multiply-accumulate.
module fir3_lane #(
	parameter int TAP_COUNT   = fir3_pkg::TAP_COUNT_DEF,
	parameter int SAMPLE_BITS = fir3_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fir3_pkg::fir3_ctl_t               ctl,
	input  logic [fir3_pkg::ACC_BITS-1:0]     coeff,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	output logic [fir3_pkg::ACC_BITS-1:0]     acc
);

	localparam int DB     = fir3_pkg::DIGIT_BITS;
	localparam int DIGITS = (SAMPLE_BITS + DB - 1) / DB;
	localparam int PAD    = DIGITS * DB;
	localparam int AB     = fir3_pkg::ACC_BITS;

	// Entry 0 holds the sample of the tap being processed.
	logic signed [SAMPLE_BITS-1:0] ring_q [TAP_COUNT];
	logic [PAD-1:0]                samp_sh_q;
	logic [AB-1:0]                 coef_sh_q;
	logic [AB-1:0]                 acc_q;

	logic [PAD-1:0]                cur_samp;
	logic signed [AB-1:0]          cur_coef;
	logic signed [DB:0]            digit_ext;
	logic signed [AB-1:0]          prod;

	always_comb begin
		cur_samp  = ctl.first ? PAD'(ring_q[0]) : samp_sh_q;
		cur_coef  = ctl.first ? coeff : coef_sh_q;
		// The highest digit carries the sign of the sample.
		digit_ext = {ctl.last & cur_samp[DB-1], cur_samp[DB-1:0]};
		prod      = cur_coef * digit_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAP_COUNT; k++) begin
				ring_q[k] <= '0;
			end
		end else if (ctl.load) begin
			ring_q[0] <= sample;
			for (int k = 1; k < TAP_COUNT; k++) begin
				ring_q[k] <= ring_q[k-1];
			end
		end else if (ctl.step && ctl.last) begin
			// After a full pass of rotations the line is back in order.
			for (int k = 0; k < TAP_COUNT - 1; k++) begin
				ring_q[k] <= ring_q[k+1];
			end
			ring_q[TAP_COUNT-1] <= ring_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q     <= acc_q + prod;
			samp_sh_q <= cur_samp >> DB;
			coef_sh_q <= cur_coef << DB;
		end
	end

	assign acc = acc_q;

endmodule

// ===== hw/rtl/fir3_ctrl.sv =====
// Sequencer: handshakes, tap and digit counters, coefficient lookup.
module fir3_ctrl #(
	parameter int TAP_COUNT       = fir3_pkg::TAP_COUNT_DEF,
	parameter int SAMPLE_BITS     = fir3_pkg::SAMPLE_BITS_DEF,
	parameter int COEFF_FRAC_BITS = fir3_pkg::COEFF_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output fir3_pkg::fir3_ctl_t           ctl,
	output logic [fir3_pkg::ACC_BITS-1:0] coeff,
	output logic                          capture
);

	localparam int DB       = fir3_pkg::DIGIT_BITS;
	localparam int DIGITS   = (SAMPLE_BITS + DB - 1) / DB;
	localparam int TAP_BITS = $clog2(TAP_COUNT);
	localparam int DIG_BITS = $clog2(DIGITS);
	localparam logic [TAP_BITS-1:0] TapLast = TAP_BITS'(TAP_COUNT - 1);
	localparam logic [DIG_BITS-1:0] DigLast = DIG_BITS'(DIGITS - 1);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		DONE
	} state_t;

	state_t              state_q;
	logic [TAP_BITS-1:0] tap_q;
	logic [DIG_BITS-1:0] dig_q;
	logic                m_tvalid_q;
	logic                out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;
	assign capture  = (state_q == DONE) && out_free;
	assign coeff    = fir3_pkg::tap_coeff(32'(tap_q), COEFF_FRAC_BITS);

	always_comb begin
		ctl.load  = s_tvalid && (state_q == IDLE);
		ctl.step  = (state_q == RUN);
		ctl.first = (dig_q == '0);
		ctl.last  = (dig_q == DigLast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			tap_q      <= '0;
			dig_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (capture) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						state_q <= RUN;
						tap_q   <= '0;
						dig_q   <= '0;
					end
				end
				RUN: begin
					if (dig_q == DigLast) begin
						dig_q <= '0;
						if (tap_q == TapLast) begin
							tap_q   <= '0;
							state_q <= DONE;
						end else begin
							tap_q <= tap_q + 1'b1;
						end
					end else begin
						dig_q <= dig_q + 1'b1;
					end
				end
				DONE: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
